// ===== hw/rtl/u16u8_pkg.sv =====
// u16u8_pkg: types and constants shared by the utf-16 to utf-8 encoder
// holds the port item structs, the encoded-job structs, the encoding constants and the queue sizing
// no dependencies
package u16u8_pkg;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_OFFSET   = 21'h10000;
    localparam logic [20:0] LIMIT_ONE     = 21'h80;
    localparam logic [20:0] LIMIT_TWO     = 21'h800;
    localparam logic [20:0] LIMIT_THREE   = 21'h10000;
    localparam logic [7:0]  LEAD_TWO      = 8'hC0;
    localparam logic [7:0]  LEAD_THREE    = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR     = 8'hF0;
    localparam logic [7:0]  CONT_MARK     = 8'h80;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_of_run;
        logic       string_end;
        logic       failed;
    } out_item_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            eos;
        logic            fail;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } job_push_t;

endpackage

// ===== hw/rtl/u16u8_front.sv =====
// u16u8_front: takes code units, tracks surrogate pairing and failure,
// and turns each unit that produces output into an encoded job
// depends on u16u8_pkg
module u16u8_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 full,
    input  u16u8_pkg::in_item_t  unit_item,
    output u16u8_pkg::job_push_t job_out
);

    logic [9:0]  held_reg;
    logic [9:0]  held_next;
    logic        pend_reg;
    logic        pend_next;
    logic        fail_reg;
    logic        fail_next;

    logic        accept;
    logic        is_high;
    logic        is_low;
    logic        fail_now;
    logic        hold;
    logic        emit_char;
    logic        failing;
    logic [20:0] value;
    u16u8_pkg::job_t job;

    assign accept  = push && !full;
    assign is_high = unit_item.code_unit[15:10] == u16u8_pkg::HIGH_SURR_TAG;
    assign is_low  = unit_item.code_unit[15:10] == u16u8_pkg::LOW_SURR_TAG;

    always_comb
    begin
        fail_now  = 1'b0;
        hold      = 1'b0;
        emit_char = 1'b0;
        value     = {5'd0, unit_item.code_unit};
        if (!fail_reg)
        begin
            if (pend_reg)
            begin
                if (is_low)
                begin
                    value     = {1'b0, held_reg, unit_item.code_unit[9:0]}
                                + u16u8_pkg::SUPP_OFFSET;
                    emit_char = 1'b1;
                end
                else
                begin
                    fail_now = 1'b1;
                end
            end
            else if (is_high)
            begin
                if (unit_item.end_of_string)
                begin
                    fail_now = 1'b1;
                end
                else
                begin
                    hold = 1'b1;
                end
            end
            else if (is_low)
            begin
                fail_now = 1'b1;
            end
            else
            begin
                emit_char = 1'b1;
            end
        end
    end

    assign failing = fail_reg || fail_now;

    // utf-8 encoding of the completed character
    always_comb
    begin
        job          = '0;
        job.eos      = unit_item.end_of_string;
        job.fail     = failing;
        if (!failing)
        begin
            if (value < u16u8_pkg::LIMIT_ONE)
            begin
                job.bytes[0] = {1'b0, value[6:0]};
                job.last_idx = 2'd0;
            end
            else if (value < u16u8_pkg::LIMIT_TWO)
            begin
                job.bytes[0] = u16u8_pkg::LEAD_TWO | {3'd0, value[10:6]};
                job.bytes[1] = u16u8_pkg::CONT_MARK | {2'd0, value[5:0]};
                job.last_idx = 2'd1;
            end
            else if (value < u16u8_pkg::LIMIT_THREE)
            begin
                job.bytes[0] = u16u8_pkg::LEAD_THREE | {4'd0, value[15:12]};
                job.bytes[1] = u16u8_pkg::CONT_MARK | {2'd0, value[11:6]};
                job.bytes[2] = u16u8_pkg::CONT_MARK | {2'd0, value[5:0]};
                job.last_idx = 2'd2;
            end
            else
            begin
                job.bytes[0] = u16u8_pkg::LEAD_FOUR | {5'd0, value[20:18]};
                job.bytes[1] = u16u8_pkg::CONT_MARK | {2'd0, value[17:12]};
                job.bytes[2] = u16u8_pkg::CONT_MARK | {2'd0, value[11:6]};
                job.bytes[3] = u16u8_pkg::CONT_MARK | {2'd0, value[5:0]};
                job.last_idx = 2'd3;
            end
        end
    end

    assign job_out.job  = job;
    assign job_out.push = accept &&
                          (failing ? unit_item.end_of_string : emit_char);

    always_comb
    begin
        held_next = held_reg;
        pend_next = pend_reg;
        fail_next = fail_reg;
        if (accept)
        begin
            if (unit_item.end_of_string)
            begin
                held_next = '0;
                pend_next = 1'b0;
                fail_next = 1'b0;
            end
            else
            begin
                held_next = hold ? unit_item.code_unit[9:0] : '0;
                pend_next = hold;
                fail_next = failing;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            pend_reg <= 1'b0;
            fail_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
            pend_reg <= pend_next;
            fail_reg <= fail_next;
        end
    end

endmodule

// ===== hw/rtl/u16u8_fifo.sv =====
// u16u8_fifo: short queue of encoded jobs between front and back
// depends on u16u8_pkg
module u16u8_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  u16u8_pkg::job_push_t wr,
    output logic                 full,
    output logic                 nonempty,
    input  logic                 rd,
    output u16u8_pkg::job_t      rd_job
);

    u16u8_pkg::job_t mem [u16u8_pkg::FIFO_DEPTH];

    logic [u16u8_pkg::FIFO_AW:0] wptr_reg;
    logic [u16u8_pkg::FIFO_AW:0] wptr_next;
    logic [u16u8_pkg::FIFO_AW:0] rptr_reg;
    logic [u16u8_pkg::FIFO_AW:0] rptr_next;
    logic                        do_wr;
    logic                        do_rd;

    assign nonempty = wptr_reg != rptr_reg;
    assign full     = (wptr_reg[u16u8_pkg::FIFO_AW] != rptr_reg[u16u8_pkg::FIFO_AW]) &&
                      (wptr_reg[u16u8_pkg::FIFO_AW-1:0] == rptr_reg[u16u8_pkg::FIFO_AW-1:0]);
    assign do_wr    = wr.push && !full;
    assign do_rd    = rd && nonempty;
    assign rd_job   = mem[rptr_reg[u16u8_pkg::FIFO_AW-1:0]];

    assign wptr_next = do_wr ? wptr_reg + 1'b1 : wptr_reg;
    assign rptr_next = do_rd ? rptr_reg + 1'b1 : rptr_reg;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wptr_reg[u16u8_pkg::FIFO_AW-1:0]] <= wr.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
        end
    end

endmodule

// ===== hw/rtl/u16u8_back.sv =====
// u16u8_back: steps through the bytes of each queued job, one a cycle while the
// result stage is free or popped, into a registered result stage
// depends on u16u8_pkg
module u16u8_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  nonempty,
    input  u16u8_pkg::job_t       rd_job,
    output logic                  rd,
    output logic                  empty,
    input  logic                  pop,
    output u16u8_pkg::out_item_t  byte_item
);

    u16u8_pkg::job_t      job_reg;
    u16u8_pkg::job_t      job_next;
    logic                 job_valid_reg;
    logic                 job_valid_next;
    logic [1:0]           idx_reg;
    logic [1:0]           idx_next;
    u16u8_pkg::out_item_t out_reg;
    u16u8_pkg::out_item_t out_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic                 load;
    logic                 advance;
    logic                 last;
    logic                 take;

    assign load    = !out_valid_reg || pop;
    assign advance = load && job_valid_reg;
    assign last    = idx_reg == job_reg.last_idx;
    assign take    = nonempty && (!job_valid_reg || (advance && last));
    assign rd      = take;

    always_comb
    begin
        out_next             = out_reg;
        out_next.out_byte    = job_reg.bytes[idx_reg];
        out_next.byte_valid  = !job_reg.fail;
        out_next.last_of_run = last;
        out_next.string_end  = last && job_reg.eos;
        out_next.failed      = job_reg.fail;

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (load)
        begin
            out_valid_next = 1'b0;
        end

        job_next       = take ? rd_job : job_reg;
        job_valid_next = take ? 1'b1 : ((advance && last) ? 1'b0 : job_valid_reg);
        idx_next       = take ? 2'd0 : (advance ? idx_reg + 2'd1 : idx_reg);
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty     = !out_valid_reg;
    assign byte_item = out_reg;

endmodule

// ===== hw/rtl/utf16_to_utf8_encoder.sv =====
// utf16_to_utf8_encoder: utf-16 code units in, utf-8 bytes out
// depends on u16u8_pkg, u16u8_front, u16u8_fifo, u16u8_back
//
// input side is a queue write port: an item (code_unit, end_of_string) is
// taken at a clock edge with push high and full low
// output side is a queue read port: while empty is low the oldest result is
// on byte_item, and it is taken at a clock edge with pop high
// each character gives one to four byte results; a held high surrogate gives
// none until its partner arrives; a failed string gives one status result
// (byte_valid low, failed high) on its end unit and nothing from the failing unit up to it
// the first byte passes through the queue, the job register and the result register
// throughput is one byte per cycle while pop keeps the result stage moving, set by
// the single byte stepper in the back end: ascii text runs at one unit per cycle,
// a character of n bytes holds the back end until its n bytes are out while the
// front keeps filling a 4-job queue
// when pop stays low the result register holds, the queue fills and full
// rises; no item or byte is ever dropped
// reset clears surrogate and failure state, empties the queue and the
// result stage
module utf16_to_utf8_encoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  u16u8_pkg::in_item_t  unit_item,
    output logic                 empty,
    input  logic                 pop,
    output u16u8_pkg::out_item_t byte_item
);

    u16u8_pkg::job_push_t job_wr;
    u16u8_pkg::job_t      rd_job;
    logic                 nonempty;
    logic                 rd;

    u16u8_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .unit_item (unit_item),
        .job_out   (job_wr)
    );

    u16u8_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (job_wr),
        .full     (full),
        .nonempty (nonempty),
        .rd       (rd),
        .rd_job   (rd_job)
    );

    u16u8_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .nonempty  (nonempty),
        .rd_job    (rd_job),
        .rd        (rd),
        .empty     (empty),
        .pop       (pop),
        .byte_item (byte_item)
    );

endmodule

// ===== hw/rtl/u16u8_checker.sv =====
// u16u8_checker: port-level checks for utf16_to_utf8_encoder
// depends on u16u8_pkg; bound to the top level below
module u16u8_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 push,
    input logic                 full,
    input u16u8_pkg::in_item_t  unit_item,
    input logic                 empty,
    input logic                 pop,
    input u16u8_pkg::out_item_t byte_item
);

    // stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(byte_item)))
        else $error("stalled result changed");

    // failure status is a bare end-of-string marker
    a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && byte_item.failed) |->
            (!byte_item.byte_valid && byte_item.last_of_run && byte_item.string_end))
        else $error("bad failure status result");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && byte_item.string_end) |-> byte_item.last_of_run)
        else $error("string end not on last result");

    a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !byte_item.byte_valid) |-> byte_item.failed)
        else $error("status result without failure");

    // a byte result never carries the failure flag
    a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && byte_item.byte_valid) |-> !byte_item.failed)
        else $error("byte result marked failed");

endmodule

bind utf16_to_utf8_encoder u16u8_checker u_checker (.*);
